FILE: design/assert_macros.svh
// Assertion macros shared by the sliding window maximum RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside of reset.
`define SWM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition must never be true outside of reset.
`define SWM_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: design/swm_pkg.sv
// Shared constants for the sliding window maximum block.
// No dependencies.
package swm_pkg;

    // Width of the window length configuration register.
    localparam int CFG_WIDTH = 7;

    // Window length after reset.
    localparam int CFG_RESET = 1;

endpackage

FILE: design/sliding_window_maximum_core.sv
// Sliding window maximum core: sequencer, two stack memories and output register.
// Depends on swm_pkg, swm_ram, swm_obuf and assert_macros.svh.
//
// This block reports the maximum of the most recent window_length signed samples. It keeps
// the window as a max-queue made of two stacks, each held in its own single-port-write,
// registered-read memory: the in-stack stores every entry's sample and the running maximum
// of itself and the entries below it, the out-stack stores running maxima only. While the
// window fills no result is given; the sample that fills it gives the first result, and from
// then on every sample gives one. A sample with end_of_stream set empties the window after
// its result, or at once if it gives none, and any write of window_length (0 acts as 1,
// values above WINDOW_MAX act as WINDOW_MAX) empties it as well. A sample taken while the
// window fills is pushed at once, and the sample that fills it then also passes through
// the emit step. Once the window is full, as long as the out-stack is not empty, a sample
// pops it, fetches the new out-stack top and is pushed in one step before the emit step; a
// sample that finds it empty first moves the in-stack across, one entry per cycle through
// the in-stack read port while the oldest entry drops out, then is pushed and emits. The
// configuration port is ready only while the sequencer is idle, and a configuration
// transaction on offer holds off the sample channel for that cycle. The output register
// lets a new transaction be accepted while the previous result still waits on a stalled
// receiver.
module sliding_window_maximum_core #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [swm_pkg::CFG_WIDTH-1:0]     i_cfg_data,
    // Sample channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_sample,
    input  logic                              i_end_of_stream,
    // Result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]    o_window_max
);

`include "assert_macros.svh"

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SW = SAMPLE_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_XFER,
        ST_EMIT
    } t_state;

    // Signed maximum of two samples.
    function automatic logic [SW-1:0] f_larger(input logic [SW-1:0] a, input logic [SW-1:0] b);
        return ($signed(a) >= $signed(b)) ? a : b;
    endfunction

    // Control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_in_cnt, n_in_cnt;
    logic [CW-1:0]   r_out_cnt, n_out_cnt;
    logic [CW-1:0]   r_win, n_win;
    logic            r_rd_pend, n_rd_pend;
    logic            r_use_rd, n_use_rd;
    logic            r_eos, n_eos;

    // Payload state
    logic [SW-1:0]   r_in_top, n_in_top;
    logic [SW-1:0]   r_out_top, n_out_top;
    logic [SW-1:0]   r_sample, n_sample;

    // Memory ports
    logic            in_we, in_re;
    logic [AW-1:0]   in_waddr, in_raddr;
    logic [2*SW-1:0] in_wdata, in_rdata;
    logic            out_we, out_re;
    logic [AW-1:0]   out_waddr, out_raddr;
    logic [SW-1:0]   out_wdata, out_rdata;

    // Helpers
    logic            cfg_fire;
    logic            in_fire;
    logic [CW:0]     size;
    logic [CW:0]     win_ext;
    logic [SW-1:0]   push_max;
    logic [CW-1:0]   out_below;
    logic [CW-1:0]   in_below;
    logic [SW-1:0]   xfer_val;
    logic [SW-1:0]   xfer_max;
    logic [SW-1:0]   out_top_eff;
    logic [SW-1:0]   emit_max;
    logic            obuf_load;
    logic            obuf_free;

    // A configuration write takes precedence, so the sample waits while one is offered.
    assign o_stall     = (r_state != ST_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign in_fire     = i_valid && !o_stall;

    assign size    = {1'b0, r_in_cnt} + {1'b0, r_out_cnt};
    assign win_ext = {1'b0, r_win};

    // Running maximum of a new in-stack entry.
    assign push_max = (r_in_cnt != '0) ? f_larger(r_in_top, i_sample) : i_sample;

    // Entry that becomes the out-stack top after a pop, and the next in-stack entry to move.
    assign out_below = r_out_cnt - CW'(2);
    assign in_below  = r_in_cnt - CW'(1);

    // Entry arriving from the in-stack during a transfer; its sample is in the upper half.
    assign xfer_val = in_rdata[2*SW-1:SW];
    assign xfer_max = (r_out_cnt != '0) ? f_larger(r_out_top, xfer_val) : xfer_val;

    // After a pop the new out-stack top comes straight from the read register.
    assign out_top_eff = r_use_rd ? out_rdata : r_out_top;
    assign emit_max    = (r_out_cnt != '0) ? f_larger(r_in_top, out_top_eff) : r_in_top;

    always_comb begin
        n_state   = r_state;
        n_in_cnt  = r_in_cnt;
        n_out_cnt = r_out_cnt;
        n_win     = r_win;
        n_rd_pend = r_rd_pend;
        n_use_rd  = r_use_rd;
        n_eos     = r_eos;
        n_in_top  = r_in_top;
        n_out_top = r_out_top;
        n_sample  = r_sample;
        in_we     = 1'b0;
        in_waddr  = '0;
        in_wdata  = '0;
        in_re     = 1'b0;
        in_raddr  = '0;
        out_we    = 1'b0;
        out_waddr = '0;
        out_wdata = '0;
        out_re    = 1'b0;
        out_raddr = '0;
        obuf_load = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (cfg_fire) begin
                    // A new window size always restarts with an empty window.
                    if (i_cfg_data == '0) begin
                        n_win = CW'(1);
                    end else if (int'(i_cfg_data) > WINDOW_MAX) begin
                        n_win = CW'(WINDOW_MAX);
                    end else begin
                        n_win = CW'(i_cfg_data);
                    end
                    n_in_cnt  = '0;
                    n_out_cnt = '0;
                end else if (in_fire) begin
                    n_sample = i_sample;
                    n_eos    = i_end_of_stream;
                    if (size < win_ext) begin
                        // Window still filling: push only.
                        in_we    = 1'b1;
                        in_waddr = r_in_cnt[AW-1:0];
                        in_wdata = {i_sample, push_max};
                        n_in_top = push_max;
                        n_in_cnt = r_in_cnt + CW'(1);
                        n_use_rd = 1'b0;
                        if (size + (CW+1)'(1) == win_ext) begin
                            n_state = ST_EMIT;
                        end else if (i_end_of_stream) begin
                            n_in_cnt  = '0;
                            n_out_cnt = '0;
                        end
                    end else if (r_out_cnt != '0) begin
                        // Pop the oldest from the out-stack, fetch the entry below it
                        // and push the new sample in the same cycle.
                        out_re    = (r_out_cnt > CW'(1));
                        out_raddr = out_below[AW-1:0];
                        n_use_rd  = (r_out_cnt > CW'(1));
                        n_out_cnt = r_out_cnt - CW'(1);
                        in_we     = 1'b1;
                        in_waddr  = r_in_cnt[AW-1:0];
                        in_wdata  = {i_sample, push_max};
                        n_in_top  = push_max;
                        n_in_cnt  = r_in_cnt + CW'(1);
                        n_state   = ST_EMIT;
                    end else begin
                        n_rd_pend = 1'b0;
                        n_state   = ST_XFER;
                    end
                end
            end

            ST_XFER: begin
                // Write side: the entry read last cycle lands on the out-stack.
                if (r_rd_pend) begin
                    out_we    = 1'b1;
                    out_waddr = r_out_cnt[AW-1:0];
                    out_wdata = xfer_max;
                    n_out_top = xfer_max;
                    n_out_cnt = r_out_cnt + CW'(1);
                end
                // Read side: move every entry but the bottom one, which is the oldest
                // sample and leaves the window right here.
                if (r_in_cnt > CW'(1)) begin
                    in_re     = 1'b1;
                    in_raddr  = in_below[AW-1:0];
                    n_in_cnt  = r_in_cnt - CW'(1);
                    n_rd_pend = 1'b1;
                end else begin
                    n_rd_pend = 1'b0;
                    if (!r_rd_pend) begin
                        // In-stack now holds only the new sample.
                        in_we    = 1'b1;
                        in_waddr = '0;
                        in_wdata = {r_sample, r_sample};
                        n_in_top = r_sample;
                        n_in_cnt = CW'(1);
                        n_use_rd = 1'b0;
                        n_state  = ST_EMIT;
                    end
                end
            end

            ST_EMIT: begin
                if (obuf_free) begin
                    obuf_load = 1'b1;
                    n_out_top = out_top_eff;
                    n_state   = ST_IDLE;
                    if (r_eos) begin
                        n_in_cnt  = '0;
                        n_out_cnt = '0;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
            r_win     <= CW'(swm_pkg::CFG_RESET);
            r_rd_pend <= 1'b0;
            r_use_rd  <= 1'b0;
            r_eos     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_in_cnt  <= n_in_cnt;
            r_out_cnt <= n_out_cnt;
            r_win     <= n_win;
            r_rd_pend <= n_rd_pend;
            r_use_rd  <= n_use_rd;
            r_eos     <= n_eos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_top  <= n_in_top;
        r_out_top <= n_out_top;
        r_sample  <= n_sample;
    end

    // In-stack: {sample, running maximum} per entry.
    swm_ram #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (2 * SW)
    ) u_in_ram (
        .i_clk   (i_clk),
        .i_we    (in_we),
        .i_waddr (in_waddr),
        .i_wdata (in_wdata),
        .i_re    (in_re),
        .i_raddr (in_raddr),
        .o_rdata (in_rdata)
    );

    // Out-stack: running maximum per entry.
    swm_ram #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (SW)
    ) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (out_we),
        .i_waddr (out_waddr),
        .i_wdata (out_wdata),
        .i_re    (out_re),
        .i_raddr (out_raddr),
        .o_rdata (out_rdata)
    );

    swm_obuf #(
        .WIDTH (SW)
    ) u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (obuf_load),
        .i_data  (emit_max),
        .o_free  (obuf_free),
        .o_valid (o_valid),
        .o_data  (o_window_max),
        .i_stall (i_stall)
    );

    // Entries held in both stacks never exceed the window, also during a transfer.
    `SWM_ASSERT(a_size_in_window, i_clk, i_rst_n, size <= win_ext, "stack contents exceed window")

    // A new result only ever comes out of the emit step.
    `SWM_ASSERT(a_result_from_emit, i_clk, i_rst_n, $rose(o_valid) |-> $past(r_state == ST_EMIT), "result without emit step")

    // A transfer read in flight always leaves at least the oldest entry behind.
    `SWM_NEVER(a_xfer_underflow, i_clk, i_rst_n, r_rd_pend && (r_in_cnt == '0), "in-stack drained during transfer")

    // The out-stack never holds a whole window, since the newest sample sits on the in-stack.
    `SWM_ASSERT(a_out_below_max, i_clk, i_rst_n, r_out_cnt < CW'(WINDOW_MAX), "out-stack overfull")

endmodule

FILE: design/swm_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered and holds until the next read. No dependencies.
module swm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/swm_obuf.sv
// Single-entry output register for the result channel (valid/stall).
// Lets the sequencer finish a result while the previous one waits. No dependencies.
module swm_obuf #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_free,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_stall
);

    logic             r_valid;
    logic             n_valid;
    logic [WIDTH-1:0] r_data;

    // The slot can take a new result when it is empty or being drained now.
    assign o_free  = !r_valid || !i_stall;
    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
